FILE: rtl/etrm_pkg.sv
// Shared types and constants for the Euler angle to rotation matrix block.
package etrm_pkg;

    // Rotation order codes
    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_XZY = 3'd1,
        ORD_YXZ = 3'd2,
        ORD_YZX = 3'd3,
        ORD_ZXY = 3'd4,
        ORD_ZYX = 3'd5
    } t_order;

    // Fraction bits of the internal sine polynomial
    localparam int QB = 30;

    // Odd Taylor terms of sin(pi/2 * t), Q30, Horner order after the t^11 term
    localparam logic signed [31:0] HORNER_INIT = -32'sd3864;
    localparam logic signed [31:0] HORNER_C [5] = '{
        32'sd172272,
        -32'sd5026995,
        32'sd85569306,
        -32'sd693598668,
        32'sd1686629713
    };

endpackage

FILE: rtl/etrm_if.sv
// Valid/ready channel interfaces for angle input and matrix output.
interface etrm_in_if #(
    parameter int AW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic signed [AW-1:0] angle_x;
    logic signed [AW-1:0] angle_y;
    logic signed [AW-1:0] angle_z;
    logic [2:0]           func;

    modport source (output valid, angle_x, angle_y, angle_z, func, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, func, output ready);
endinterface

interface etrm_out_if #(
    parameter int SW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] r00;
    logic signed [SW-1:0] r01;
    logic signed [SW-1:0] r02;
    logic signed [SW-1:0] r10;
    logic signed [SW-1:0] r11;
    logic signed [SW-1:0] r12;
    logic signed [SW-1:0] r20;
    logic signed [SW-1:0] r21;
    logic signed [SW-1:0] r22;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    output ready);
endinterface

FILE: rtl/etrm_sin.sv
// Pipelined binary-angle sine: quadrant fold, Horner polynomial, round.
module etrm_sin #(
    parameter int AW = 16,
    parameter int FB = 14
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [AW-1:0]       i_angle,
    output logic signed [FB+1:0] o_sin
);
    import etrm_pkg::*;

    localparam int SW = FB + 2;
    localparam int SH = QB - FB;
    localparam logic [32:0] HALF  = (SH > 0) ? (33'd1 << (SH - 1)) : 33'd0;
    localparam logic [32:0] ONE_F = 33'd1 << FB;
    localparam logic [61:0] QHALF = 62'd1 << (QB - 1);
    localparam logic [30:0] ONE_Q = 31'd1 << QB;

    // stage 0: fold into the first quadrant
    logic [1:0]  w_q;
    logic [30:0] w_t0;
    logic [30:0] w_t;
    logic [30:0] r_t0;
    logic        r_neg0;

    assign w_q  = i_angle[AW-1:AW-2];
    assign w_t0 = {1'b0, i_angle[AW-3:0], {(32 - AW){1'b0}}};
    assign w_t  = w_q[0] ? (ONE_Q - w_t0) : w_t0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0   <= w_t;
            r_neg0 <= w_q[1];
        end
    end

    // stage 1: t squared
    logic [61:0] w_p1;
    logic [30:0] r_t1;
    logic [30:0] r_t2;
    logic        r_neg1;

    assign w_p1 = r_t0 * r_t0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= r_t0;
            r_t2   <= 31'((w_p1 + QHALF) >> QB);
            r_neg1 <= r_neg0;
        end
    end

    // stages 2..6: one Horner step each
    logic signed [31:0] r_acc [1:5];
    logic [30:0]        r_ht  [1:5];
    logic [30:0]        r_ht2 [1:4];
    logic               r_hn  [1:5];

    for (genvar k = 0; k < 5; k++) begin : g_horner
        logic signed [31:0] w_ain;
        logic [30:0]        w_tin;
        logic [30:0]        w_t2in;
        logic               w_nin;
        logic [31:0]        w_mg;
        logic [61:0]        w_pr;
        logic [31:0]        w_rd;
        logic signed [31:0] w_sv;

        if (k == 0) begin : g_first
            assign w_ain  = HORNER_INIT;
            assign w_tin  = r_t1;
            assign w_t2in = r_t2;
            assign w_nin  = r_neg1;
        end else begin : g_next
            assign w_ain  = r_acc[k];
            assign w_tin  = r_ht[k];
            assign w_t2in = r_ht2[k];
            assign w_nin  = r_hn[k];
        end

        // rounded half away from zero on the magnitude
        assign w_mg = w_ain[31] ? 32'(-w_ain) : 32'(w_ain);
        assign w_pr = w_mg[30:0] * w_t2in;
        assign w_rd = 32'((w_pr + QHALF) >> QB);
        assign w_sv = w_ain[31] ? -signed'(w_rd) : signed'(w_rd);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k+1] <= w_sv + HORNER_C[k];
                r_ht[k+1]  <= w_tin;
                r_hn[k+1]  <= w_nin;
            end
        end

        // t squared is not needed past the last Horner step
        if (k < 4) begin : g_t2
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ht2[k+1] <= w_t2in;
                end
            end
        end
    end

    // stage 7: final multiply by t, negative clamps to zero
    logic [31:0] w_mg7;
    logic [61:0] w_pr7;
    logic [31:0] r_u;
    logic        r_un;

    assign w_mg7 = r_acc[5][31] ? 32'(-r_acc[5]) : 32'(r_acc[5]);
    assign w_pr7 = w_mg7[30:0] * r_ht[5];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u  <= r_acc[5][31] ? 32'd0 : 32'((w_pr7 + QHALF) >> QB);
            r_un <= r_hn[5];
        end
    end

    // stage 8: round to output precision, limit, apply quadrant sign
    logic [32:0]          w_v;
    logic [32:0]          w_c;
    logic signed [SW-1:0] r_sin;

    assign w_v = ({1'b0, r_u} + HALF) >> SH;
    assign w_c = (w_v > ONE_F) ? ONE_F : w_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_un ? -signed'(SW'(w_c)) : signed'(SW'(w_c));
        end
    end

    assign o_sin = r_sin;

endmodule

FILE: rtl/etrm_mat.sv
// Matrix products: pair products, triple products, then order select and saturate.
module etrm_mat #(
    parameter int FB = 14
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  etrm_pkg::t_order     i_func,
    input  logic signed [FB+1:0] i_sx,
    input  logic signed [FB+1:0] i_cx,
    input  logic signed [FB+1:0] i_sy,
    input  logic signed [FB+1:0] i_cy,
    input  logic signed [FB+1:0] i_sz,
    input  logic signed [FB+1:0] i_cz,
    output logic signed [FB+1:0] o_r [9]
);
    import etrm_pkg::*;

    localparam int SW = FB + 2;
    localparam logic [2*SW-1:0]    PHALF = (2*SW)'(1) << (FB - 1);
    localparam logic signed [SW:0] ONE_W = (SW+1)'(1) << FB;
    localparam logic signed [SW-1:0] ONE_S = SW'(1) << FB;
    localparam logic signed [SW-1:0] ZERO  = '0;

    function automatic logic signed [SW-1:0] f_mul(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
        logic [SW-1:0]   ma;
        logic [SW-1:0]   mb;
        logic [2*SW-1:0] p;
        logic [2*SW-1:0] r;
        ma = a[SW-1] ? SW'(-a) : SW'(a);
        mb = b[SW-1] ? SW'(-b) : SW'(b);
        p  = ma * mb;
        r  = (p + PHALF) >> FB;
        f_mul = (a[SW-1] ^ b[SW-1]) ? -signed'(SW'(r)) : signed'(SW'(r));
    endfunction

    // a + b or a - b, limited to plus or minus one
    function automatic logic signed [SW-1:0] f_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b,
                                                   input logic sub);
        logic signed [SW:0] s;
        s = sub ? ({a[SW-1], a} - {b[SW-1], b}) : ({a[SW-1], a} + {b[SW-1], b});
        if (s > ONE_W) begin
            f_add = ONE_S;
        end else if (s < -ONE_W) begin
            f_add = -ONE_S;
        end else begin
            f_add = s[SW-1:0];
        end
    endfunction

    // stage 1: pair products
    logic signed [SW-1:0] r_cycz, r_szcy, r_sxcy, r_sxcz, r_szcx, r_cxcz;
    logic signed [SW-1:0] r_sxsz, r_cxcy, r_sycz, r_sxsy, r_sycx, r_sysz;
    logic signed [SW-1:0] r_sx1, r_sy1, r_sz1, r_cx1, r_cy1, r_cz1;
    t_order               r_func1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz  <= f_mul(i_cy, i_cz);
            r_szcy  <= f_mul(i_sz, i_cy);
            r_sxcy  <= f_mul(i_sx, i_cy);
            r_sxcz  <= f_mul(i_sx, i_cz);
            r_szcx  <= f_mul(i_sz, i_cx);
            r_cxcz  <= f_mul(i_cx, i_cz);
            r_sxsz  <= f_mul(i_sx, i_sz);
            r_cxcy  <= f_mul(i_cx, i_cy);
            r_sycz  <= f_mul(i_sy, i_cz);
            r_sxsy  <= f_mul(i_sx, i_sy);
            r_sycx  <= f_mul(i_sy, i_cx);
            r_sysz  <= f_mul(i_sy, i_sz);
            r_sx1   <= i_sx;
            r_sy1   <= i_sy;
            r_sz1   <= i_sz;
            r_cx1   <= i_cx;
            r_cy1   <= i_cy;
            r_cz1   <= i_cz;
            r_func1 <= i_func;
        end
    end

    // stage 2: triple products, pairs carried along
    logic signed [SW-1:0] r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7;
    logic signed [SW-1:0] q_cycz, q_szcy, q_sxcy, q_sxcz, q_szcx, q_cxcz;
    logic signed [SW-1:0] q_sxsz, q_cxcy, q_sycz, q_sxsy, q_sycx, q_sysz;
    logic signed [SW-1:0] r_sx2, r_sy2, r_sz2;
    t_order               r_func2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0    <= f_mul(r_sxsy, r_cz1);
            r_t1    <= f_mul(r_sxsy, r_sz1);
            r_t2    <= f_mul(r_sycx, r_cz1);
            r_t3    <= f_mul(r_sycx, r_sz1);
            r_t4    <= f_mul(r_sysz, r_cx1);
            r_t5    <= f_mul(r_szcx, r_cy1);
            r_t6    <= f_mul(r_sxsz, r_cy1);
            r_t7    <= f_mul(r_sxcy, r_cz1);
            q_cycz  <= r_cycz;
            q_szcy  <= r_szcy;
            q_sxcy  <= r_sxcy;
            q_sxcz  <= r_sxcz;
            q_szcx  <= r_szcx;
            q_cxcz  <= r_cxcz;
            q_sxsz  <= r_sxsz;
            q_cxcy  <= r_cxcy;
            q_sycz  <= r_sycz;
            q_sxsy  <= r_sxsy;
            q_sycx  <= r_sycx;
            q_sysz  <= r_sysz;
            r_sx2   <= r_sx1;
            r_sy2   <= r_sy1;
            r_sz2   <= r_sz1;
            r_func2 <= r_func1;
        end
    end

    // stage 3: terms for the selected order
    logic signed [SW-1:0] n_r [9];
    logic signed [SW-1:0] r_r [9];

    always_comb begin
        unique case (r_func2)
            ORD_XYZ: begin
                n_r[0] = f_add(q_cycz, ZERO, 1'b0);
                n_r[1] = f_add(ZERO, q_szcy, 1'b1);
                n_r[2] = f_add(r_sy2, ZERO, 1'b0);
                n_r[3] = f_add(r_t0, q_szcx, 1'b0);
                n_r[4] = f_add(q_cxcz, r_t1, 1'b1);
                n_r[5] = f_add(ZERO, q_sxcy, 1'b1);
                n_r[6] = f_add(q_sxsz, r_t2, 1'b1);
                n_r[7] = f_add(q_sxcz, r_t4, 1'b0);
                n_r[8] = f_add(q_cxcy, ZERO, 1'b0);
            end
            ORD_XZY: begin
                n_r[0] = f_add(q_cycz, ZERO, 1'b0);
                n_r[1] = f_add(ZERO, r_sz2, 1'b1);
                n_r[2] = f_add(q_sycz, ZERO, 1'b0);
                n_r[3] = f_add(q_sxsy, r_t5, 1'b0);
                n_r[4] = f_add(q_cxcz, ZERO, 1'b0);
                n_r[5] = f_add(r_t4, q_sxcy, 1'b1);
                n_r[6] = f_add(r_t6, q_sycx, 1'b1);
                n_r[7] = f_add(q_sxcz, ZERO, 1'b0);
                n_r[8] = f_add(q_cxcy, r_t1, 1'b0);
            end
            ORD_YXZ: begin
                n_r[0] = f_add(q_cycz, r_t1, 1'b0);
                n_r[1] = f_add(r_t0, q_szcy, 1'b1);
                n_r[2] = f_add(q_sycx, ZERO, 1'b0);
                n_r[3] = f_add(q_szcx, ZERO, 1'b0);
                n_r[4] = f_add(q_cxcz, ZERO, 1'b0);
                n_r[5] = f_add(ZERO, r_sx2, 1'b1);
                n_r[6] = f_add(r_t6, q_sycz, 1'b1);
                n_r[7] = f_add(q_sysz, r_t7, 1'b0);
                n_r[8] = f_add(q_cxcy, ZERO, 1'b0);
            end
            ORD_YZX: begin
                n_r[0] = f_add(q_cycz, ZERO, 1'b0);
                n_r[1] = f_add(q_sxsy, r_t5, 1'b1);
                n_r[2] = f_add(r_t6, q_sycx, 1'b0);
                n_r[3] = f_add(r_sz2, ZERO, 1'b0);
                n_r[4] = f_add(q_cxcz, ZERO, 1'b0);
                n_r[5] = f_add(ZERO, q_sxcz, 1'b1);
                n_r[6] = f_add(ZERO, q_sycz, 1'b1);
                n_r[7] = f_add(q_sxcy, r_t3, 1'b0);
                n_r[8] = f_add(q_cxcy, r_t1, 1'b1);
            end
            ORD_ZXY: begin
                n_r[0] = f_add(q_cycz, r_t1, 1'b1);
                n_r[1] = f_add(ZERO, q_szcx, 1'b1);
                n_r[2] = f_add(q_sycz, r_t6, 1'b0);
                n_r[3] = f_add(r_t0, q_szcy, 1'b0);
                n_r[4] = f_add(q_cxcz, ZERO, 1'b0);
                n_r[5] = f_add(q_sysz, r_t7, 1'b1);
                n_r[6] = f_add(ZERO, q_sycx, 1'b1);
                n_r[7] = f_add(r_sx2, ZERO, 1'b0);
                n_r[8] = f_add(q_cxcy, ZERO, 1'b0);
            end
            ORD_ZYX: begin
                n_r[0] = f_add(q_cycz, ZERO, 1'b0);
                n_r[1] = f_add(r_t0, q_szcx, 1'b1);
                n_r[2] = f_add(r_t2, q_sxsz, 1'b0);
                n_r[3] = f_add(q_szcy, ZERO, 1'b0);
                n_r[4] = f_add(q_cxcz, r_t1, 1'b0);
                n_r[5] = f_add(r_t3, q_sxcz, 1'b1);
                n_r[6] = f_add(ZERO, r_sy2, 1'b1);
                n_r[7] = f_add(q_sxcy, ZERO, 1'b0);
                n_r[8] = f_add(q_cxcy, ZERO, 1'b0);
            end
            default: begin
                // unused order codes give the identity
                for (int i = 0; i < 9; i++) begin
                    n_r[i] = (i % 4 == 0) ? ONE_S : ZERO;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= n_r;
        end
    end

    assign o_r = r_r;

endmodule

FILE: rtl/euler_to_rotation_matrix_top.sv
// Top level: Euler angles to 3x3 rotation matrix, fully pipelined.
//
//  channel | dir | fields                                 | transfer when
//  i_in    | in  | angle_x angle_y angle_z func           | valid & ready
//  o_out   | out | r00 r01 r02 r10 r11 r12 r20 r21 r22    | valid & ready
//
// One item per cycle sustained while the output is not held. The sine units
// hold the quadrant fold, t^2, five Horner steps, final multiply and rounding;
// the matrix unit holds pair products, triple products, combine and limit.
// Reset clears only the stage valid bits.
// Every stage advances together; when the output is held, the whole pipe
// holds and the input is not ready.
module euler_to_rotation_matrix_top #(
    parameter int ANGLE_WIDTH = 16,
    parameter int FRAC_BITS   = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    etrm_in_if.sink    i_in,
    etrm_out_if.source o_out
);
    import etrm_pkg::*;

    localparam int SW      = FRAC_BITS + 2;
    localparam int SIN_LAT = 9;
    localparam int LAT     = SIN_LAT + 3;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [SW-1:0]   ONE_S   = SW'(1) << FRAC_BITS;

    logic           w_en;
    logic [LAT-1:0] r_vld;
    t_order         r_func [SIN_LAT];

    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_func[0] <= t_order'(i_in.func);
            for (int i = 1; i < SIN_LAT; i++) begin
                r_func[i] <= r_func[i-1];
            end
        end
    end

    logic [ANGLE_WIDTH-1:0] w_ang [6];
    logic signed [SW-1:0]   w_trig [6];

    // sin x, cos x, sin y, cos y, sin z, cos z
    assign w_ang[0] = i_in.angle_x;
    assign w_ang[1] = i_in.angle_x + QUARTER;
    assign w_ang[2] = i_in.angle_y;
    assign w_ang[3] = i_in.angle_y + QUARTER;
    assign w_ang[4] = i_in.angle_z;
    assign w_ang[5] = i_in.angle_z + QUARTER;

    for (genvar g = 0; g < 6; g++) begin : g_trig
        etrm_sin #(
            .AW (ANGLE_WIDTH),
            .FB (FRAC_BITS)
        ) u_sin (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (w_ang[g]),
            .o_sin   (w_trig[g])
        );
    end

    logic signed [SW-1:0] w_r [9];

    etrm_mat #(
        .FB (FRAC_BITS)
    ) u_mat (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_func (r_func[SIN_LAT-1]),
        .i_sx   (w_trig[0]),
        .i_cx   (w_trig[1]),
        .i_sy   (w_trig[2]),
        .i_cy   (w_trig[3]),
        .i_sz   (w_trig[4]),
        .i_cz   (w_trig[5]),
        .o_r    (w_r)
    );

    assign o_out.r00 = w_r[0];
    assign o_out.r01 = w_r[1];
    assign o_out.r02 = w_r[2];
    assign o_out.r10 = w_r[3];
    assign o_out.r11 = w_r[4];
    assign o_out.r12 = w_r[5];
    assign o_out.r20 = w_r[6];
    assign o_out.r21 = w_r[7];
    assign o_out.r22 = w_r[8];

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("stage valid bits moved during a stall");

    a_load_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted item did not enter the pipe");

    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.r00 <= ONE_S) && (o_out.r00 >= -ONE_S)
                     && (o_out.r11 <= ONE_S) && (o_out.r11 >= -ONE_S)
                     && (o_out.r22 <= ONE_S) && (o_out.r22 >= -ONE_S))
        else $error("diagonal entry out of range");

    a_offdiag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.r01 <= ONE_S) && (o_out.r01 >= -ONE_S)
                     && (o_out.r12 <= ONE_S) && (o_out.r12 >= -ONE_S)
                     && (o_out.r20 <= ONE_S) && (o_out.r20 >= -ONE_S))
        else $error("off-diagonal entry out of range");

endmodule
